@@ hw/rtl/ick_pkg.sv @@
// Shared types and constants for the iambic CW keyer.
`timescale 1ns / 1ps

package ick_pkg;

   localparam int DIT_BITS  = 15;
   localparam int MODE_BITS = 2;
   localparam int LOAD_BITS = DIT_BITS + 2;   // room for three dit lengths
   localparam int ADDR_BITS = 1;
   localparam int DATA_BITS = DIT_BITS;

   localparam logic [DIT_BITS-1:0] DIT_LENGTH_RESET = DIT_BITS'(48000 * 12 / (10 * 20));

   localparam logic [MODE_BITS-1:0] MODE_STRAIGHT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_IAMBIC_A = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_IAMBIC_B = 2'd2;

   localparam logic [ADDR_BITS-1:0] REG_KEYER_MODE = 1'd0;
   localparam logic [ADDR_BITS-1:0] REG_DIT_LENGTH = 1'd1;

   typedef struct packed {
      logic [MODE_BITS-1:0] keyer_mode;
      logic [DIT_BITS-1:0]  dit_length;
   } cfg_type;

endpackage

@@ hw/rtl/ick_req_if.sv @@
// Paddle sample channel: one word per sample tick.
`timescale 1ns / 1ps

interface ick_req_if;
   logic valid;
   logic ready;
   logic dit_paddle;
   logic dah_paddle;

   modport source (output valid, output dit_paddle, output dah_paddle, input ready);
   modport sink (input valid, input dit_paddle, input dah_paddle, output ready);
endinterface

@@ hw/rtl/ick_rsp_if.sv @@
// Key-down result channel: one word per sample tick.
`timescale 1ns / 1ps

interface ick_rsp_if;
   logic valid;
   logic ready;
   logic key_down;

   modport source (output valid, output key_down, input ready);
   modport sink (input valid, input key_down, output ready);
endinterface

@@ hw/rtl/ick_csr_if.sv @@
// Register write channel of the keyer.
`timescale 1ns / 1ps

interface ick_csr_if;
   logic                   valid;
   logic                   ready;
   logic [ick_pkg::ADDR_BITS-1:0] addr;
   logic [ick_pkg::DATA_BITS-1:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

@@ hw/rtl/ick_csr.sv @@
// Configuration registers: keyer mode and dit length.
`timescale 1ns / 1ps

module ick_csr (
   input  logic              clock,
   input  logic              reset,
   ick_csr_if.sink           csr_chan,
   output ick_pkg::cfg_type  cfg
);
   import ick_pkg::*;

   logic [MODE_BITS-1:0] mode_ff;
   logic [DIT_BITS-1:0]  dit_length_ff;
   logic                 wr;

   assign csr_chan.ready = 1'b1;
   assign wr = csr_chan.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_STRAIGHT;
         dit_length_ff <= DIT_LENGTH_RESET;
      end else if (wr) begin
         case (csr_chan.addr)
            REG_KEYER_MODE: mode_ff       <= csr_chan.data[MODE_BITS-1:0];
            REG_DIT_LENGTH: dit_length_ff <= csr_chan.data[DIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.keyer_mode = mode_ff;
   assign cfg.dit_length = dit_length_ff;

endmodule

@@ hw/rtl/ick_fsm.sv @@
// Keyer state machine: phase, element timer, paddle memories and key output register.
`timescale 1ns / 1ps

module ick_fsm #(
   parameter int TIMER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ick_pkg::cfg_type cfg,
   input  logic             step,
   input  logic             dit,
   input  logic             dah,
   output logic             key_down
);
   import ick_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_DIT   = 2'd1,
      PH_DAH   = 2'd2,
      PH_SPACE = 2'd3
   } phase_type;

   localparam int WideBits = (TIMER_BITS > LOAD_BITS) ? TIMER_BITS : LOAD_BITS;
   localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};
   localparam logic [WideBits-1:0]   TimerMaxWide = WideBits'(TimerMax);

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  dit_mem_ff, dit_mem_in;
   logic                  dah_mem_ff, dah_mem_in;
   logic                  last_dit_ff, last_dit_in;
   logic                  key_ff, key_in;

   logic [DIT_BITS-1:0]   unit_len;
   logic [LOAD_BITS-1:0]  dah_len;
   logic [WideBits-1:0]   dit_wide, dah_wide;
   logic [TIMER_BITS-1:0] dit_load, dah_load;
   logic                  expired;
   logic                  dit_mem_or, dah_mem_or;

   // element lengths, saturated to the timer width
   assign unit_len = (cfg.dit_length == '0) ? DIT_BITS'(1) : cfg.dit_length;
   assign dah_len  = LOAD_BITS'(unit_len) + {1'b0, unit_len, 1'b0};
   assign dit_wide = WideBits'(unit_len);
   assign dah_wide = WideBits'(dah_len);
   assign dit_load = (dit_wide > TimerMaxWide) ? TimerMax : TIMER_BITS'(dit_wide);
   assign dah_load = (dah_wide > TimerMaxWide) ? TimerMax : TIMER_BITS'(dah_wide);

   assign expired    = (timer_ff <= TIMER_BITS'(1));
   assign dit_mem_or = dit_mem_ff | dit;
   assign dah_mem_or = dah_mem_ff | dah;

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      dit_mem_in  = dit_mem_ff;
      dah_mem_in  = dah_mem_ff;
      last_dit_in = last_dit_ff;
      key_in      = key_ff;
      if (cfg.keyer_mode == MODE_STRAIGHT) begin
         key_in = dit;
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               key_in     = 1'b0;
               dit_mem_in = 1'b0;
               dah_mem_in = 1'b0;
               if (dit) begin
                  phase_in    = PH_DIT;
                  timer_in    = dit_load;
                  last_dit_in = 1'b1;
               end else if (dah) begin
                  phase_in    = PH_DAH;
                  timer_in    = dah_load;
                  last_dit_in = 1'b0;
               end
            end
            PH_DIT, PH_DAH: begin
               key_in     = 1'b1;
               dit_mem_in = dit_mem_or;
               dah_mem_in = dah_mem_or;
               if (expired) begin
                  phase_in = PH_SPACE;
                  timer_in = dit_load;
               end else begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end
            end
            default: begin
               key_in     = 1'b0;
               dit_mem_in = dit_mem_or;
               dah_mem_in = dah_mem_or;
               if (!expired) begin
                  timer_in = timer_ff - TIMER_BITS'(1);
               end else if (!dit && !dah && cfg.keyer_mode == MODE_IAMBIC_A) begin
                  phase_in = PH_IDLE;
                  timer_in = '0;
               end else begin
                  timer_in = '0;
                  if ((!last_dit_ff && dit_mem_or) || (!(last_dit_ff && dah_mem_or) && dit)) begin
                     phase_in    = PH_DIT;
                     timer_in    = dit_load;
                     last_dit_in = 1'b1;
                     dit_mem_in  = 1'b0;
                     dah_mem_in  = 1'b0;
                  end else if ((last_dit_ff && dah_mem_or) || dah) begin
                     phase_in    = PH_DAH;
                     timer_in    = dah_load;
                     last_dit_in = 1'b0;
                     dit_mem_in  = 1'b0;
                     dah_mem_in  = 1'b0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         dit_mem_ff  <= 1'b0;
         dah_mem_ff  <= 1'b0;
         last_dit_ff <= 1'b0;
         key_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         dit_mem_ff  <= dit_mem_in;
         dah_mem_ff  <= dah_mem_in;
         last_dit_ff <= last_dit_in;
         key_ff      <= key_in;
      end
   end

   assign key_down = key_ff;

`ifndef SYNTHESIS
   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> timer_ff == '0)
      else $error("timer not clear in idle");
   a_dit_marks_last: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIT |-> last_dit_ff)
      else $error("dit phase without last-dit mark");
   a_dah_marks_last: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DAH |-> !last_dit_ff)
      else $error("dah phase with last-dit mark");
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      step && cfg.keyer_mode != MODE_STRAIGHT && phase_ff == PH_IDLE |=> !key_ff)
      else $error("key down on the tick leaving idle");
   a_straight_freeze: assert property (@(posedge clock) disable iff (reset)
      step && cfg.keyer_mode == MODE_STRAIGHT |=> $stable(phase_ff) && $stable(timer_ff))
      else $error("iambic state moved in straight mode");
`endif

endmodule

@@ hw/rtl/iambic_cw_keyer.sv @@
// Iambic CW keyer top level: input register, keyer state machine, result register.
// An accepted word is held in the input register, then its result word in the result register.
// One word per cycle unless stalled; the keyer's single-pass next-state logic sets this.
// Backpressure on the result side stalls both registers; one word is held in each.
// Reset (synchronous, active high): straight mode, dit length 2880 ticks, keyer idle.
`timescale 1ns / 1ps

module iambic_cw_keyer #(
   parameter int TIMER_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   ick_req_if.sink   req_chan,
   ick_rsp_if.source rsp_chan,
   ick_csr_if.sink   csr_chan
);
   import ick_pkg::*;

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   logic    dit_ff, dah_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    req_take;
   logic    step;
   logic    key_down;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign step           = in_valid_ff && advance;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // paddle word register
   always_ff @(posedge clock) begin
      if (req_take) begin
         dit_ff <= req_chan.dit_paddle;
         dah_ff <= req_chan.dah_paddle;
      end
   end

   ick_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ick_fsm #(
      .TIMER_BITS (TIMER_BITS)
   ) u_fsm (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .step     (step),
      .dit      (dit_ff),
      .dah      (dah_ff),
      .key_down (key_down)
   );

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.key_down = key_down;

endmodule

@@ test/iambic_cw_keyer_tb.sv @@
// Self-checking testbench for the iambic CW keyer, with its own keyer predictor.
`timescale 1ns / 1ps

module iambic_cw_keyer_tb;
   import ick_pkg::*;

   localparam int TIMER_BITS   = 12;
   localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 1;
   localparam int DAH_UNITS    = 3;
   localparam int RANDOM_WORDS = 800;
   localparam logic [MODE_BITS-1:0] MODE_IAMBIC_B_ALT = 2'd3;

   typedef enum logic [1:0] {KP_IDLE, KP_DIT, KP_DAH, KP_SPACE} keyer_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ick_req_if req_bus();
   ick_rsp_if rsp_bus();
   ick_csr_if csr_bus();

   iambic_cw_keyer #(.TIMER_BITS(TIMER_BITS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [MODE_BITS-1:0]  cfg_mode    = MODE_STRAIGHT;
   logic [DIT_BITS-1:0]   cfg_dit_len = DIT_LENGTH_RESET;
   keyer_phase_type       kp_phase    = KP_IDLE;
   logic [TIMER_BITS-1:0] kp_timer    = '0;
   logic                  kp_dit_mem  = 1'b0;
   logic                  kp_dah_mem  = 1'b0;
   logic                  kp_last_dit = 1'b0;

   logic key_down_due[$];
   int   fail_count   = 0;
   int   words_sent   = 0;
   int   hold_request = 0;
   bit   send_gaps    = 1'b1;
   bit   rsp_stalls   = 1'b1;

   function automatic logic [TIMER_BITS-1:0] element_load(input int unsigned units);
      longint unsigned ticks;
      ticks = (cfg_dit_len == '0) ? 64'd1 : 64'(cfg_dit_len);
      ticks = ticks * units;
      if (ticks > TIMER_MAX) return '1;
      return ticks[TIMER_BITS-1:0];
   endfunction

   function automatic void begin_element(input logic is_dit);
      kp_phase    = is_dit ? KP_DIT : KP_DAH;
      kp_timer    = element_load(is_dit ? 1 : DAH_UNITS);
      kp_last_dit = is_dit;
   endfunction

   function automatic logic timer_done();
      if (kp_timer <= 1) begin
         kp_timer = '0;
         return 1'b1;
      end
      kp_timer = kp_timer - 1'b1;
      return 1'b0;
   endfunction

   function automatic logic keyer_step(input logic dit, input logic dah);
      if (cfg_mode == MODE_STRAIGHT) return dit;
      if (kp_phase == KP_IDLE) begin
         kp_dit_mem = 1'b0;
         kp_dah_mem = 1'b0;
         if (dit) begin_element(1'b1);
         else if (dah) begin_element(1'b0);
         return 1'b0;
      end
      if (dit) kp_dit_mem = 1'b1;
      if (dah) kp_dah_mem = 1'b1;
      if (kp_phase != KP_SPACE) begin
         if (timer_done()) begin
            kp_phase = KP_SPACE;
            kp_timer = element_load(1);
         end
         return 1'b1;
      end
      if (!timer_done()) return 1'b0;
      if (!dit && !dah && cfg_mode == MODE_IAMBIC_A) begin
         kp_phase = KP_IDLE;
         return 1'b0;
      end
      if (!kp_last_dit && (dit || kp_dit_mem)) begin_element(1'b1);
      else if (kp_last_dit && (dah || kp_dah_mem)) begin_element(1'b0);
      else if (dit) begin_element(1'b1);
      else if (dah) begin_element(1'b0);
      else kp_phase = KP_IDLE;
      if (kp_phase != KP_IDLE) begin
         kp_dit_mem = 1'b0;
         kp_dah_mem = 1'b0;
      end
      return 1'b0;
   endfunction

   function automatic void flag_error(input string what, input logic want, input logic got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected key_down %b, got %b", $time, what, want, got);
   endfunction

   always @(posedge clock) begin : key_down_check
      logic want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (key_down_due.size() == 0) begin
            flag_error("unexpected word", 1'bx, rsp_bus.key_down);
         end else begin
            want = key_down_due.pop_front();
            if (rsp_bus.key_down !== want) flag_error("mismatch", want, rsp_bus.key_down);
         end
      end
   end

   // receiver: random stall per word, long hold on request
   initial begin : rsp_ready_drive
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         stall = rsp_stalls ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready) && hold_request == 0) @(posedge clock);
      end
   end

   task automatic send_word(input logic dit, input logic dah);
      int gap;
      gap = send_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.dit_paddle <= dit;
      req_bus.dah_paddle <= dah;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      key_down_due.push_back(keyer_step(dit, dah));
      words_sent++;
   endtask

   task automatic send_run(input logic dit, input logic dah, input int count);
      repeat (count) send_word(dit, dah);
   endtask

   task automatic send_random_word();
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (key_down_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ADDR_BITS-1:0] idx, input logic [DATA_BITS-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         REG_KEYER_MODE: cfg_mode = val[MODE_BITS-1:0];
         REG_DIT_LENGTH: cfg_dit_len = val[DIT_BITS-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      repeat (8) send_random_word();
      wait_drained();
   endtask

   task automatic test_elements();
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_IAMBIC_B));
      write_reg(REG_DIT_LENGTH, '0);
      send_word(1'b1, 1'b0);
      send_run(1'b0, 1'b0, 3);
      send_word(1'b0, 1'b1);
      send_run(1'b0, 1'b0, 5);
      send_run(1'b1, 1'b1, 6);
      send_run(1'b0, 1'b0, 3);
      wait_drained();
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_IAMBIC_A));
      write_reg(REG_DIT_LENGTH, DATA_BITS'(2));
      send_run(1'b1, 1'b1, 5);
      send_run(1'b0, 1'b0, 4);
      wait_drained();
      // dah memory latched during a dit
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_IAMBIC_B_ALT));
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b1);
      send_run(1'b0, 1'b0, 12);
      wait_drained();
   endtask

   task automatic test_mode_freeze();
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_IAMBIC_B));
      write_reg(REG_DIT_LENGTH, DATA_BITS'(3));
      send_run(1'b0, 1'b1, 4);
      wait_drained();
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_STRAIGHT));
      repeat (6) send_random_word();
      wait_drained();
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_IAMBIC_B));
      send_run(1'b0, 1'b0, 16);
      wait_drained();
   endtask

   task automatic test_saturation();
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_IAMBIC_A));
      send_gaps  = 1'b0;
      rsp_stalls = 1'b0;
      // let any running element finish first
      send_run(1'b0, 1'b0, 100);
      wait_drained();
      // three dit lengths overflow the timer
      write_reg(REG_DIT_LENGTH, DATA_BITS'(1366));
      send_word(1'b0, 1'b1);
      send_run(1'b0, 1'b0, 150);
      send_gaps  = 1'b1;
      rsp_stalls = 1'b1;
      wait_drained();
   endtask

   task automatic test_backpressure();
      write_reg(REG_KEYER_MODE, DATA_BITS'(MODE_IAMBIC_B));
      write_reg(REG_DIT_LENGTH, DATA_BITS'(2));
      hold_request = 80;
      send_gaps = 1'b0;
      send_run(1'b1, 1'b1, 30);
      send_run(1'b0, 1'b1, 20);
      send_gaps = 1'b1;
      wait_drained();
   endtask

   task automatic test_random();
      int start;
      int next_cfg;
      int dl;
      int pick;
      logic [1:0] paddles;
      logic [DATA_BITS-1:0] csr_value;
      start    = words_sent;
      next_cfg = start;
      while (words_sent - start < RANDOM_WORDS) begin
         if (words_sent >= next_cfg) begin
            wait_drained();
            pick = $urandom_range(0, 9);
            csr_value = DATA_BITS'($urandom);
            csr_value[MODE_BITS-1:0] = (pick == 0) ? MODE_STRAIGHT :
                                       (pick < 4)  ? MODE_IAMBIC_A :
                                       (pick < 9)  ? MODE_IAMBIC_B : MODE_IAMBIC_B_ALT;
            write_reg(REG_KEYER_MODE, csr_value);
            pick = $urandom_range(0, 9);
            csr_value = DATA_BITS'((pick == 0) ? 0 :
                                   (pick < 8) ? $urandom_range(1, 4) : $urandom_range(5, 24));
            write_reg(REG_DIT_LENGTH, csr_value);
            next_cfg = words_sent + $urandom_range(80, 200);
         end
         dl = (cfg_dit_len == '0) ? 1 : int'(cfg_dit_len);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            paddles = 2'($urandom_range(1, 3));
            send_run(paddles[1], paddles[0], $urandom_range(1, 6 * dl));
            send_run(1'b0, 1'b0, $urandom_range(0, 5 * dl));
         end else if (pick < 9) begin
            repeat ($urandom_range(1, 4)) send_random_word();
         end else begin
            wait_drained();
         end
      end
      wait_drained();
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.dit_paddle = 1'b0;
      req_bus.dah_paddle = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.addr       = REG_KEYER_MODE;
      csr_bus.data       = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_elements();
      test_mode_freeze();
      test_backpressure();
      test_random();
      test_saturation();
      repeat (4) @(posedge clock);
      if (key_down_due.size() != 0) begin
         $display("%0d expected words never arrived", key_down_due.size());
         fail_count += key_down_due.size();
      end
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ iambic_cw_keyer.f @@
hw/rtl/ick_pkg.sv
hw/rtl/ick_req_if.sv
hw/rtl/ick_rsp_if.sv
hw/rtl/ick_csr_if.sv
hw/rtl/ick_csr.sv
hw/rtl/ick_fsm.sv
hw/rtl/iambic_cw_keyer.sv
test/iambic_cw_keyer_tb.sv
